@@ hdl/dad_pkg.sv @@
// Types, constants and calendar helpers shared by the date adder modules.
package dad_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned AddW   = 16;
  localparam int unsigned NumW   = 17;  // day number after adding, up to 366 + 65535
  localparam int unsigned RemW   = 9;   // year modulo 400
  localparam int unsigned YlenW  = 9;
  localparam int unsigned MlenW  = 5;

  localparam logic [MonW-1:0]  MonMax    = 4'd12;
  localparam logic [MonW-1:0]  IdxLast   = 4'd11;
  localparam logic [MonW-1:0]  IdxFeb    = 4'd1;
  localparam logic [MonW-1:0]  MonFeb    = 4'd2;
  localparam logic [RemW-1:0]  RemLast   = 9'd399;
  localparam logic [5:0]       Recip25   = 6'd41;  // 41/1024 as 1/25, exact floor below 1024
  localparam logic [4:0]       Base25    = 5'd25;
  localparam logic [RemW-1:0]  Cent1     = 9'd100;
  localparam logic [RemW-1:0]  Cent2     = 9'd200;
  localparam logic [RemW-1:0]  Cent3     = 9'd300;
  localparam logic [YlenW-1:0] LenLeap   = 9'd366;
  localparam logic [YlenW-1:0] LenCommon = 9'd365;
  localparam logic             StsOk     = 1'b0;
  localparam logic             StsBad    = 1'b1;

  typedef struct packed {
    logic [DayW-1:0]  start_day;
    logic [MonW-1:0]  start_month;
    logic [YearW-1:0] start_year;
    logic [AddW-1:0]  days_to_add;
  } dad_in_t;

  typedef struct packed {
    logic [DayW-1:0]  new_day;
    logic [MonW-1:0]  new_month;
    logic [YearW-1:0] new_year;
    logic             status;
  } dad_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mod_load;
    logic doy;
    logic year_step;
    logic month_step;
    logic out_load;
  } dad_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic invalid;
    logic year_done;
    logic month_done;
    logic out_free;
  } dad_sts_t;

  // leap test on year mod 400: divisible by 4 and not a whole century, or mod 400 is zero
  function automatic logic leap_of_rem(input logic [RemW-1:0] r);
    return (r[1:0] == 2'd0) && (r != Cent1) && (r != Cent2) && (r != Cent3);
  endfunction

  // length of month at zero-based index
  function automatic logic [MlenW-1:0] month_len(input logic [MonW-1:0] idx, input logic leap);
    logic [MlenW-1:0] len;
    case (idx)
      4'd1:                        len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:     len = 5'd30;
      default:                     len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the months before the zero-based index, common year
  function automatic logic [8:0] cum_days(input logic [MonW-1:0] idx);
    logic [8:0] c;
    case (idx)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd59;
      4'd3:    c = 9'd90;
      4'd4:    c = 9'd120;
      4'd5:    c = 9'd151;
      4'd6:    c = 9'd181;
      4'd7:    c = 9'd212;
      4'd8:    c = 9'd243;
      4'd9:    c = 9'd273;
      4'd10:   c = 9'd304;
      4'd11:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/dad_dp.sv @@
// Datapath of the date adder: year mod 400, day number, year and month steps.
module dad_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dad_pkg::dad_in_t  in_data_i,
  input  dad_pkg::dad_cmd_t cmd_i,
  output dad_pkg::dad_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output dad_pkg::dad_out_t out_data_o
);
  import dad_pkg::*;

  logic [DayW-1:0]  day_q;
  logic [MonW-1:0]  mon_q;
  logic [YearW-1:0] year_q,  year_d;
  logic [AddW-1:0]  add_q;
  logic [RemW-1:0]  rem_q,   rem_d;
  logic [NumW-1:0]  n_q,     n_d;
  logic [MonW-1:0]  idx_q,   idx_d;
  logic             out_valid_q;
  dad_out_t         out_q;

  logic             leap;
  logic [YlenW-1:0] ylen;
  logic [MlenW-1:0] mlen;
  logic [YearW-5:0] yhi;
  logic [15:0]      yprod;
  logic [9:0]       ymul;
  logic [9:0]       ydiff;
  logic             invalid;

  assign leap    = leap_of_rem(rem_q);
  assign ylen    = leap ? LenLeap : LenCommon;
  assign mlen    = month_len(idx_q, leap);
  assign invalid = (day_q == '0) || (mon_q == '0) || (mon_q > MonMax);

  // year mod 400 = 16 * ((year / 16) mod 25) + year mod 16, quotient by reciprocal
  assign yhi   = year_q[YearW-1:4];
  assign yprod = 16'(yhi) * 16'(Recip25);
  assign ymul  = 10'(yprod[15:10]) * 10'(Base25);
  assign ydiff = yhi - ymul;

  assign sts_o.invalid    = invalid;
  assign sts_o.year_done  = n_q <= NumW'(ylen);
  assign sts_o.month_done = (idx_q == IdxLast) || (n_q <= NumW'(mlen));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    year_d = year_q;
    rem_d  = rem_q;
    n_d    = n_q;
    idx_d  = idx_q;
    if (cmd_i.load) begin
      year_d = in_data_i.start_year;
      rem_d  = '0;
    end else if (cmd_i.mod_load) begin
      rem_d = {ydiff[4:0], year_q[3:0]};
    end else if (cmd_i.doy) begin
      n_d   = NumW'(day_q) + NumW'(cum_days(mon_q - 4'd1))
            + NumW'(leap && (mon_q > MonFeb)) + NumW'(add_q);
      idx_d = '0;
    end else if (cmd_i.year_step) begin
      n_d    = n_q - NumW'(ylen);
      year_d = year_q + YearW'(1);
      rem_d  = (rem_q == RemLast) ? '0 : rem_q + RemW'(1);
    end else if (cmd_i.month_step) begin
      n_d   = n_q - NumW'(mlen);
      idx_d = idx_q + MonW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q <= in_data_i.start_day;
      mon_q <= in_data_i.start_month;
      add_q <= in_data_i.days_to_add;
    end
    year_q <= year_d;
    rem_q  <= rem_d;
    n_q    <= n_d;
    idx_q  <= idx_d;
    if (cmd_i.out_load) begin
      if (invalid) begin
        out_q <= '{new_day: '0, new_month: '0, new_year: '0, status: StsBad};
      end else begin
        out_q <= '{new_day: n_q[DayW-1:0], new_month: idx_q + MonW'(1),
                   new_year: year_q, status: StsOk};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while waiting");

  a_year_step_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.year_step |-> (n_q > NumW'(ylen)))
    else $error("year stepped past the final year");

  a_month_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.month_step |-> (idx_q < IdxLast))
    else $error("month walk ran past December");

endmodule

@@ hdl/dad_ctrl.sv @@
// Controller of the date adder: sequences year mod 400, day number, year and month phases.
module dad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dad_pkg::dad_sts_t sts_i,
  output dad_pkg::dad_cmd_t cmd_o
);
  import dad_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DOY,
    ST_YEAR,
    ST_MONTH,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MOD;
        end
      end
      ST_MOD: begin
        if (sts_i.invalid) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.mod_load = 1'b1;
          state_d        = ST_DOY;
        end
      end
      ST_DOY: begin
        cmd_o.doy = 1'b1;
        state_d   = ST_YEAR;
      end
      ST_YEAR: begin
        if (sts_i.year_done) state_d = ST_MONTH;
        else cmd_o.year_step = 1'b1;
      end
      ST_MONTH: begin
        if (sts_i.month_done) state_d = ST_OUT;
        else cmd_o.month_step = 1'b1;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MOD))
    else $error("accepted item did not start the year mod 400 phase");

  a_mod_before_doy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DOY) |-> ($past(state_q) == ST_MOD))
    else $error("day number formed before year mod 400 was ready");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

endmodule

@@ hdl/date_add_days_unit.sv @@
// Top level of the Gregorian date adder: controller and datapath.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | in_data_i  (start day, month, year, days)
//  out     | output    | out_valid_o/out_ready_i| out_data_o (new day, month, year, status)
//
// One item at a time: accept, year mod 400, day number, one step per whole year
// (180 at most) plus a final check, one per month step (11 at most) plus a
// final check, then load the result once the result register is free.
// An invalid date skips straight to the result register.
// Reset clears the controller and the result valid flag; no clearing pass.
// A waiting result does not block acceptance; the next result waits for it.
module date_add_days_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dad_pkg::dad_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dad_pkg::dad_out_t out_data_o
);
  import dad_pkg::*;

  dad_cmd_t cmd;
  dad_sts_t sts;

  dad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dad_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
